@@ src/coarse_fine_valve_regulator_core_assert.svh @@
// Assertion macros shared by the coarse/fine valve regulator RTL.
// No dependencies; taken in by `include in the modules that check themselves.
`ifndef COARSE_FINE_VALVE_REGULATOR_CORE_ASSERT_SVH
`define COARSE_FINE_VALVE_REGULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CFVR_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cfvr same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CFVR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cfvr next-cycle check failed");

`endif

@@ src/cfvr_pkg.sv @@
// Types and constants of the coarse/fine valve regulator.
// No dependencies; imported by every module of the block.
package cfvr_pkg;

    localparam int P_W     = 37;   // pressure in uPa
    localparam int D_W     = P_W + 1;
    localparam int E_W     = D_W + 1;
    localparam int FLOW_W  = 14;
    localparam int BOIL_W  = 8;
    localparam int LOAD_W  = 10;
    localparam int POS_W   = 10;   // coarse / fine valve position
    localparam int FPOS_W  = 7;    // flow valve position
    localparam int SPOS_W  = POS_W + 2;
    localparam int QC_W    = 10;   // coarse step quotient
    localparam int QF_W    = 9;    // fine step quotient (only inside fine window)
    localparam int RF_W    = 27;   // fine remainder, enough below the window top
    localparam int BITS_PER_STAGE = 2;
    localparam int DIV_STAGES     = QC_W / BITS_PER_STAGE;
    localparam int FE_STAGES      = DIV_STAGES + 1;

    localparam logic [P_W-1:0]   CSTEP2    = 37'd202447350;
    localparam logic [RF_W-1:0]  FSTEP2    = 27'd202650;
    localparam logic [RF_W-1:0]  FSTEP     = 27'd101325;
    localparam logic [RF_W-1:0]  FINE_HIGH = 27'd101325000;
    localparam logic signed [E_W-1:0] E_HI = 39'sd101325;
    localparam logic signed [E_W-1:0] E_LO = -39'sd101223675;
    localparam logic [POS_W-1:0]  POS_MAX    = 10'd1000;
    localparam logic [FPOS_W-1:0] FLOW_MAX   = 7'd100;
    localparam logic [FLOW_W:0]   FLOW_BAND  = 15'd90;
    localparam logic [BOIL_W-1:0] BOIL_LIMIT = 8'd100;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_PRESSURE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO_FLOW     = 1'd1;

    typedef enum logic [1:0] {
        MODE_TICK,
        MODE_LOAD_COARSE,
        MODE_LOAD_FINE,
        MODE_LOAD_FLOW
    } mode_t;

    typedef struct packed {
        mode_t             mode;
        logic              enabled;
        logic [P_W-1:0]    pressure;
        logic [P_W-1:0]    pressure_target;
        logic [BOIL_W-1:0] boiling_level;
        logic [FLOW_W-1:0] flow;
        logic [FLOW_W-1:0] flow_target;
        logic [LOAD_W-1:0] load_value;
    } item_t;

    // One word in flight through the front pipeline.
    typedef struct packed {
        mode_t                  mode;
        logic                   run;
        logic                   d_pos;
        logic signed [D_W-1:0]  d;
        logic [P_W-1:0]         mag;
        logic [P_W-1:0]         rem_c;
        logic [QC_W-1:0]        q_c;
        logic [RF_W-1:0]        rem_f;
        logic [QF_W-1:0]        q_f;
        logic                   fine_win;
        logic                   flow_hi;
        logic                   flow_lo;
        logic [POS_W-1:0]       load_pos;
        logic [FPOS_W-1:0]      load_flow;
    } fe_item_t;

    // Classified word handed from front to back.
    typedef struct packed {
        mode_t                  mode;
        logic                   run;
        logic                   d_pos;
        logic signed [D_W-1:0]  d;
        logic [QC_W-1:0]        q_c;
        logic [QF_W-1:0]        q_f;
        logic                   fine_win;
        logic                   flow_hi;
        logic                   flow_lo;
        logic [POS_W-1:0]       load_pos;
        logic [FPOS_W-1:0]      load_flow;
    } cmd_t;

    typedef struct packed {
        logic [POS_W-1:0]  coarse_valve;
        logic [POS_W-1:0]  fine_valve;
        logic [FPOS_W-1:0] flow_valve;
    } result_t;

endpackage

@@ src/coarse_fine_valve_regulator_core.sv @@
// Top level of the coarse/fine valve regulator: stream ports and config port.
// Depends on cfvr_pkg, cfvr_front, cfvr_queue and cfvr_back.
//
//  channel   | direction | handshake               | contents
//  ----------+-----------+-------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/tready    | one regulator word (mode in tuser)
//  m_axis    | out       | m_axis_tvalid/tready    | valve positions after that word
//  cfg       | in        | cfg_we (no wait)        | auto_pressure (0), auto_flow (1)
//
// One word per cycle sustained while m_axis keeps up. The front pipe forms the
// pressure error in one stage, then a five stage restoring divider (two quotient
// bits per stage) derives the coarse and fine step counts; the queue and the
// position update register follow before the result is presented on m_axis.
// Reset: all valve positions 0, both auto bits 1; no memory needs clearing.
// A stall on m_axis fills the queue and then holds the front pipe; s_axis_tready
// drops only while the front's last stage is blocked.
module coarse_fine_valve_regulator_core
    import cfvr_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // enabled[0], pressure[37:1], pressure_target[74:38], boiling_level[82:75],
    // flow[96:83], flow_target[110:97], load_value[120:111], zero[127:121]
    input  logic [127:0]         s_axis_tdata,
    // mode[1:0]
    input  logic [1:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // coarse_valve[9:0], fine_valve[19:10], flow_valve[26:20], zero[31:27]
    output logic [31:0]          m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data
);

    item_t   in_item;
    cmd_t    fe_cmd, bk_cmd;
    logic    fe_valid, fe_ready;
    logic    bk_valid, bk_ready;
    result_t result;

    // unpack the input word
    assign in_item.mode            = mode_t'(s_axis_tuser);
    assign in_item.enabled         = s_axis_tdata[0];
    assign in_item.pressure        = s_axis_tdata[37:1];
    assign in_item.pressure_target = s_axis_tdata[74:38];
    assign in_item.boiling_level   = s_axis_tdata[82:75];
    assign in_item.flow            = s_axis_tdata[96:83];
    assign in_item.flow_target     = s_axis_tdata[110:97];
    assign in_item.load_value      = s_axis_tdata[120:111];

    cfvr_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .cmd_valid (fe_valid),
        .cmd_ready (fe_ready),
        .cmd       (fe_cmd)
    );

    // decouples the divider pipe from the position update
    cfvr_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (fe_cmd),
        .pop_valid  (bk_valid),
        .pop_ready  (bk_ready),
        .pop_data   (bk_cmd)
    );

    cfvr_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd_valid (bk_valid),
        .cmd_ready (bk_ready),
        .cmd       (bk_cmd),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (result)
    );

    // pack the result word
    assign m_axis_tdata = {5'd0, result.flow_valve, result.fine_valve, result.coarse_valve};

endmodule

@@ src/cfvr_front.sv @@
// Front end: accepts words, forms the pressure error and divides it into step counts.
// Depends on cfvr_pkg.
module cfvr_front
    import cfvr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  item_t    in_item,
    output logic     cmd_valid,
    input  logic     cmd_ready,
    output cmd_t     cmd
);

    logic     vld_reg [FE_STAGES];
    fe_item_t pl_reg  [FE_STAGES];
    fe_item_t pl_next [FE_STAGES];
    logic     adv;

    // whole pipe holds when the last stage cannot hand off
    assign adv      = !vld_reg[FE_STAGES-1] || cmd_ready;
    assign in_ready = adv;

    // stage 0: difference, magnitude and the narrow compares
    always_comb
    begin
        pl_next[0]       = '0;
        pl_next[0].mode  = in_item.mode;
        pl_next[0].run   = (in_item.mode == MODE_TICK) && in_item.enabled
                           && (in_item.boiling_level < BOIL_LIMIT);
        pl_next[0].d     = $signed({1'b0, in_item.pressure} - {1'b0, in_item.pressure_target});
        pl_next[0].d_pos = !pl_next[0].d[D_W-1] && (pl_next[0].d != '0);
        pl_next[0].mag   = pl_next[0].d[D_W-1] ? (in_item.pressure_target - in_item.pressure)
                                               : (in_item.pressure - in_item.pressure_target);
        pl_next[0].rem_c = pl_next[0].mag;
        pl_next[0].rem_f = pl_next[0].mag[RF_W-1:0];
        pl_next[0].flow_hi = {1'b0, in_item.flow} > ({1'b0, in_item.flow_target} + FLOW_BAND);
        pl_next[0].flow_lo = ({1'b0, in_item.flow} + FLOW_BAND) < {1'b0, in_item.flow_target};
        pl_next[0].load_pos = (in_item.load_value > POS_MAX) ? POS_MAX : in_item.load_value;
        pl_next[0].load_flow = (in_item.load_value > LOAD_W'(FLOW_MAX)) ? FLOW_MAX
                                                               : in_item.load_value[FPOS_W-1:0];
    end

    // restoring division, two quotient bits per stage, coarse and fine side by side
    for (genvar s = 1; s < FE_STAGES; s++)
    begin : g_div
        always_comb
        begin
            pl_next[s] = pl_reg[s-1];
            if (s == 1)
            begin
                pl_next[s].fine_win = (pl_reg[s-1].mag > P_W'(FSTEP))
                                      && (pl_reg[s-1].mag < P_W'(FINE_HIGH));
            end
            for (int j = 0; j < BITS_PER_STAGE; j++)
            begin
                if ({1'b0, pl_next[s].rem_c} >=
                    (D_W'(CSTEP2) << (QC_W - 1 - BITS_PER_STAGE * (s - 1) - j)))
                begin
                    pl_next[s].rem_c = pl_next[s].rem_c - P_W'(D_W'(CSTEP2)
                                       << (QC_W - 1 - BITS_PER_STAGE * (s - 1) - j));
                    pl_next[s].q_c = pl_next[s].q_c
                                     | (QC_W'(1) << (QC_W - 1 - BITS_PER_STAGE * (s - 1) - j));
                end
                if ((QC_W - 1 - BITS_PER_STAGE * (s - 1) - j) < QF_W)
                begin
                    if ({1'b0, pl_next[s].rem_f} >=
                        ((RF_W + 1)'(FSTEP2) << (QC_W - 1 - BITS_PER_STAGE * (s - 1) - j)))
                    begin
                        pl_next[s].rem_f = pl_next[s].rem_f - RF_W'((RF_W + 1)'(FSTEP2)
                                           << (QC_W - 1 - BITS_PER_STAGE * (s - 1) - j));
                        pl_next[s].q_f = pl_next[s].q_f
                                     | (QF_W'(1) << (QC_W - 1 - BITS_PER_STAGE * (s - 1) - j));
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < FE_STAGES; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int s = 1; s < FE_STAGES; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < FE_STAGES; s++)
            begin
                pl_reg[s] <= pl_next[s];
            end
        end
    end

    assign cmd_valid = vld_reg[FE_STAGES-1];

    always_comb
    begin
        cmd.mode      = pl_reg[FE_STAGES-1].mode;
        cmd.run       = pl_reg[FE_STAGES-1].run;
        cmd.d_pos     = pl_reg[FE_STAGES-1].d_pos;
        cmd.d         = pl_reg[FE_STAGES-1].d;
        cmd.q_c       = pl_reg[FE_STAGES-1].q_c;
        cmd.q_f       = pl_reg[FE_STAGES-1].q_f;
        cmd.fine_win  = pl_reg[FE_STAGES-1].fine_win;
        cmd.flow_hi   = pl_reg[FE_STAGES-1].flow_hi;
        cmd.flow_lo   = pl_reg[FE_STAGES-1].flow_lo;
        cmd.load_pos  = pl_reg[FE_STAGES-1].load_pos;
        cmd.load_flow = pl_reg[FE_STAGES-1].load_flow;
    end

endmodule

@@ src/cfvr_queue.sv @@
// Short command queue between front and back of the valve regulator.
// Depends on cfvr_pkg and the assertion macro header.
`include "coarse_fine_valve_regulator_core_assert.svh"
module cfvr_queue
    import cfvr_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    cmd_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    `CFVR_ASSERT_IMPLIES(a_q_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(DEPTH))
    `CFVR_ASSERT_NEXT(a_q_fill, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 1'b1)

endmodule

@@ src/cfvr_back.sv @@
// Back end: holds the valve positions and config bits, applies one command per pop.
// Depends on cfvr_pkg and the assertion macro header.
`include "coarse_fine_valve_regulator_core_assert.svh"
module cfvr_back
    import cfvr_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic                 cfg_data,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  cmd_t                 cmd,
    output logic                 out_valid,
    input  logic                 out_ready,
    output result_t              out_data
);

    logic              auto_pressure_reg;
    logic              auto_flow_reg;
    logic [POS_W-1:0]  coarse_reg, coarse_next;
    logic [POS_W-1:0]  fine_reg, fine_next;
    logic [FPOS_W-1:0] flow_reg, flow_next;
    logic              out_valid_reg;
    logic              pop;
    logic              pos_ok;

    logic [RF_W-1:0]          fine_scaled;
    logic signed [E_W-1:0]    e;
    logic                     coarse_mv;
    logic [QC_W-1:0]          step_c;
    logic [QF_W-1:0]          step_f;
    logic signed [SPOS_W-1:0] c_sum, f_sum;
    logic [POS_W-1:0]         c_reg_out, f_reg_out;
    logic [FPOS_W-1:0]        fl_base, fl_reg_out;

    assign cmd_ready = !out_valid_reg || out_ready;
    assign pop       = cmd_valid && cmd_ready;

    // pressure part: e is the error left after the fine valve's share
    assign fine_scaled = {{(RF_W-POS_W){1'b0}}, fine_reg} * FSTEP;
    assign e           = {cmd.d[D_W-1], cmd.d} - $signed({{(E_W-RF_W){1'b0}}, fine_scaled});
    assign coarse_mv   = (e > E_HI) || (e < E_LO);
    assign step_c      = (cmd.q_c == '0) ? QC_W'(1) : cmd.q_c;
    assign step_f      = (cmd.q_f == '0) ? QF_W'(1) : cmd.q_f;

    always_comb
    begin
        c_sum = $signed({2'b00, coarse_reg});
        f_sum = $signed({2'b00, fine_reg});
        if (coarse_mv)
        begin
            c_sum = cmd.d_pos ? c_sum - $signed({2'b00, step_c})
                              : c_sum + $signed({2'b00, step_c});
        end
        if (cmd.fine_win)
        begin
            f_sum = cmd.d_pos ? f_sum - $signed({3'b000, step_f})
                              : f_sum + $signed({3'b000, step_f});
        end
        // both closed keeps the fine valve cracked open
        priority if (c_sum < 1 && f_sum < 1)
        begin
            c_sum = '0;
            f_sum = SPOS_W'(1);
        end
        else if (c_sum < 0)
        begin
            c_sum = '0;
        end
        else if (f_sum < 0)
        begin
            f_sum = '0;
        end
        else
        begin
            f_sum = f_sum;
        end
        c_reg_out = (c_sum > $signed({2'b00, POS_MAX})) ? POS_MAX : c_sum[POS_W-1:0];
        f_reg_out = (f_sum > $signed({2'b00, POS_MAX})) ? POS_MAX : f_sum[POS_W-1:0];
    end

    // flow part: one step toward the setpoint outside the band
    always_comb
    begin
        fl_base    = (flow_reg == '0) ? FPOS_W'(1) : flow_reg;
        fl_reg_out = fl_base;
        priority if (cmd.flow_hi)
        begin
            if (fl_base > FPOS_W'(1))
            begin
                fl_reg_out = fl_base - 1'b1;
            end
        end
        else if (cmd.flow_lo)
        begin
            if (fl_base < FLOW_MAX)
            begin
                fl_reg_out = fl_base + 1'b1;
            end
        end
        else
        begin
            fl_reg_out = fl_base;
        end
    end

    always_comb
    begin
        coarse_next = coarse_reg;
        fine_next   = fine_reg;
        flow_next   = flow_reg;
        unique case (cmd.mode)
            MODE_TICK:
            begin
                if (cmd.run && auto_pressure_reg)
                begin
                    coarse_next = c_reg_out;
                    fine_next   = f_reg_out;
                end
                if (cmd.run && auto_flow_reg)
                begin
                    flow_next = fl_reg_out;
                end
            end
            MODE_LOAD_COARSE: coarse_next = cmd.load_pos;
            MODE_LOAD_FINE:   fine_next   = cmd.load_pos;
            MODE_LOAD_FLOW:   flow_next   = cmd.load_flow;
            default:          coarse_next = coarse_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_pressure_reg <= 1'b1;
            auto_flow_reg     <= 1'b1;
            coarse_reg        <= '0;
            fine_reg          <= '0;
            flow_reg          <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_AUTO_PRESSURE: auto_pressure_reg <= cfg_data;
                    CFG_AUTO_FLOW:     auto_flow_reg     <= cfg_data;
                    default:           auto_flow_reg     <= auto_flow_reg;
                endcase
            end
            if (pop)
            begin
                coarse_reg    <= coarse_next;
                fine_reg      <= fine_next;
                flow_reg      <= flow_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // the positions themselves are the result of the last applied word
    assign out_valid             = out_valid_reg;
    assign out_data.coarse_valve = coarse_reg;
    assign out_data.fine_valve   = fine_reg;
    assign out_data.flow_valve   = flow_reg;

    assign pos_ok = (coarse_reg <= POS_MAX) && (fine_reg <= POS_MAX) && (flow_reg <= FLOW_MAX);

    `CFVR_ASSERT_IMPLIES(a_pos_range, clk, rst_n, 1'b1, pos_ok)
    `CFVR_ASSERT_NEXT(a_pop_shows, clk, rst_n, pop, out_valid_reg)

endmodule
